>>> rtl/locd_pkg.sv
package locd_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned KEY_W   = 40;
  localparam int unsigned SIZE_W  = 21;
  localparam int unsigned USED_W  = 24;
  localparam int unsigned HDR_W   = 8;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned CHG_W   = SIZE_W + 1;

  localparam logic [USED_W-1:0] CAPACITY_RST = 24'd1049000;
  localparam logic [SIZE_W-1:0] MAX_OBJ_RST  = 21'd102400;
  localparam logic [HDR_W-1:0]  HEADER_RST   = 8'd32;

  typedef enum logic [CIDX_W-1:0] {
    REG_CAPACITY = 2'd0,
    REG_MAX_OBJ  = 2'd1,
    REG_HEADER   = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OP,
    ST_EVICT
  } state_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOOKUP,
    CELL_EVICT,
    CELL_APPEND
  } cell_op_e;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] size;
  } entry_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    cell_op_e          op;
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] size;
  } cell_ctl_t;

endpackage

>>> rtl/locd_cell.sv
module locd_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  locd_pkg::cell_ctl_t           ctl_i,
  input  logic [locd_pkg::SIZE_W-1:0]   hit_size_i,
  input  logic                          left_valid_i,
  input  logic                          seen_i,
  input  logic [locd_pkg::SIZE_W-1:0]   found_i,
  input  locd_pkg::entry_t              right_i,
  output locd_pkg::entry_t              ent_o,
  output logic                          seen_o,
  output logic [locd_pkg::SIZE_W-1:0]   found_o
);

  logic                          valid_q, valid_d;
  logic [locd_pkg::KEY_W-1:0]    key_q, key_d;
  logic [locd_pkg::SIZE_W-1:0]   size_q, size_d;
  logic                          match;
  logic                          first;

  assign match   = valid_q && (key_q == ctl_i.key);
  assign first   = match && !seen_i;
  assign seen_o  = seen_i | match;
  assign found_o = found_i | (first ? size_q : '0);
  assign ent_o   = '{valid: valid_q, key: key_q, size: size_q};

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    size_d  = size_q;
    case (ctl_i.op)
      locd_pkg::CELL_LOOKUP: begin
        // cells from the oldest match onward take the next entry toward the tail;
        // the last valid cell takes the hit entry
        if (valid_q && (seen_i || match)) begin
          if (right_i.valid) begin
            key_d  = right_i.key;
            size_d = right_i.size;
          end else begin
            key_d  = ctl_i.key;
            size_d = hit_size_i;
          end
        end
      end
      locd_pkg::CELL_EVICT: begin
        valid_d = right_i.valid;
        key_d   = right_i.key;
        size_d  = right_i.size;
      end
      locd_pkg::CELL_APPEND: begin
        if (!valid_q && left_valid_i) begin
          valid_d = 1'b1;
          key_d   = ctl_i.key;
          size_d  = ctl_i.size;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    size_q <= size_d;
  end

endmodule

>>> rtl/lru_object_cache_directory_core.sv
// LRU object cache directory. start is taken when busy is low; each item
// gives exactly one result, shown for one cycle with done_o high, and the
// receiver cannot stall it. A lookup compares and shifts across the whole
// cell row in ST_OP. An insert passes through ST_OP, then in ST_EVICT drops
// the oldest entries as needed: the row shifts one entry per cycle toward
// the head, then the new entry is appended. A rejected insert ends in ST_OP
// and changes no entry. The result registers are separate from the request
// registers, so a new start may be given in the cycle done_o is high.
// Configuration writes are taken at any edge with cfg_we_i high and must
// only be made while the block is idle.
module lru_object_cache_directory_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request
  input  logic                          start,
  output logic                          busy,
  input  logic                          mode_i,
  input  logic [locd_pkg::KEY_W-1:0]    key_i,
  input  logic [locd_pkg::SIZE_W-1:0]   obj_size_i,
  // result
  output logic                          done_o,
  output logic                          hit_o,
  output logic [locd_pkg::SIZE_W-1:0]   found_size_o,
  output logic                          rejected_o,
  output logic [locd_pkg::CNT_W-1:0]    evicted_count_o,
  output logic [locd_pkg::USED_W-1:0]   used_bytes_o,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [locd_pkg::CIDX_W-1:0]   cfg_idx_i,
  input  logic [locd_pkg::CFG_W-1:0]    cfg_data_i
);

  localparam int unsigned N = locd_pkg::ENTRIES;

  // configuration registers
  logic [locd_pkg::USED_W-1:0] cap_q;
  logic [locd_pkg::SIZE_W-1:0] max_q;
  logic [locd_pkg::HDR_W-1:0]  hdr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= locd_pkg::CAPACITY_RST;
      max_q <= locd_pkg::MAX_OBJ_RST;
      hdr_q <= locd_pkg::HEADER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        locd_pkg::REG_CAPACITY: cap_q <= cfg_data_i;
        locd_pkg::REG_MAX_OBJ:  max_q <= cfg_data_i[locd_pkg::SIZE_W-1:0];
        locd_pkg::REG_HEADER:   hdr_q <= cfg_data_i[locd_pkg::HDR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // request latch
  logic                          mode_q;
  logic [locd_pkg::KEY_W-1:0]    key_q;
  logic [locd_pkg::SIZE_W-1:0]   size_q;

  locd_pkg::state_e              state_q, state_d;
  logic [locd_pkg::USED_W-1:0]   total_q, total_d;
  logic [locd_pkg::CNT_W-1:0]    cnt_q, cnt_d;

  logic                          done_q, done_d;
  logic                          hit_q, hit_d;
  logic [locd_pkg::SIZE_W-1:0]   found_q, found_d;
  logic                          rej_q, rej_d;
  logic [locd_pkg::CNT_W-1:0]    evc_q, evc_d;
  logic [locd_pkg::USED_W-1:0]   used_q, used_d;

  logic                          accept;
  assign accept = start && !busy;
  assign busy   = (state_q != locd_pkg::ST_IDLE);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      key_q  <= key_i;
      size_q <= obj_size_i;
    end
  end

  // cell row: slot 0 is the oldest entry, valid slots form a prefix
  locd_pkg::cell_ctl_t           ctl;
  locd_pkg::entry_t              ent [N];
  logic                          seen [N+1];
  logic [locd_pkg::SIZE_W-1:0]   found [N+1];

  assign seen[0]  = 1'b0;
  assign found[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    locd_pkg::entry_t right;
    logic             left_valid;
    if (i == N - 1) begin : g_tail
      assign right = '0;
    end else begin : g_mid
      assign right = ent[i+1];
    end
    if (i == 0) begin : g_head
      assign left_valid = 1'b1;
    end else begin : g_body
      assign left_valid = ent[i-1].valid;
    end
    locd_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .hit_size_i   (found[N]),
      .left_valid_i (left_valid),
      .seen_i       (seen[i]),
      .found_i      (found[i]),
      .right_i      (right),
      .ent_o        (ent[i]),
      .seen_o       (seen[i+1]),
      .found_o      (found[i+1])
    );
  end

  // charge and budget arithmetic
  logic [locd_pkg::CHG_W-1:0]    charge;
  logic [locd_pkg::CHG_W-1:0]    head_charge;
  logic                          too_big;
  logic                          need_evict;
  logic [locd_pkg::USED_W-1:0]   after_evict;
  logic [locd_pkg::USED_W-1:0]   base_used;
  logic                          lookup_hit;

  assign charge      = {1'b0, size_q} + locd_pkg::CHG_W'(hdr_q);
  assign head_charge = {1'b0, ent[0].size} + locd_pkg::CHG_W'(hdr_q);
  assign too_big     = (size_q > max_q) ||
                       (locd_pkg::USED_W'(charge) > cap_q);
  // evict while the row is not empty and either over budget or full
  assign need_evict  = ent[0].valid &&
                       (((locd_pkg::USED_W+1)'(total_q) +
                         (locd_pkg::USED_W+1)'(charge) > {1'b0, cap_q}) ||
                        ent[N-1].valid);
  assign after_evict = (locd_pkg::USED_W'(head_charge) >= total_q) ? '0 :
                       total_q - locd_pkg::USED_W'(head_charge);
  assign base_used   = ent[0].valid ? total_q : '0;
  assign lookup_hit  = seen[N];

  // row operation for this cycle, broadcast to every cell
  always_comb begin
    ctl.op   = locd_pkg::CELL_HOLD;
    ctl.key  = key_q;
    ctl.size = size_q;
    case (state_q)
      locd_pkg::ST_OP: begin
        if (!mode_q) begin
          ctl.op = locd_pkg::CELL_LOOKUP;
        end
      end
      locd_pkg::ST_EVICT: begin
        if (need_evict) begin
          ctl.op = locd_pkg::CELL_EVICT;
        end else begin
          ctl.op = locd_pkg::CELL_APPEND;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    total_d  = total_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    hit_d    = hit_q;
    found_d  = found_q;
    rej_d    = rej_q;
    evc_d    = evc_q;
    used_d   = used_q;
    case (state_q)
      locd_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = locd_pkg::ST_OP;
        end
      end
      locd_pkg::ST_OP: begin
        if (!mode_q) begin
          // lookup: compare in every cell, move the hit entry to the tail
          done_d   = 1'b1;
          hit_d    = lookup_hit;
          found_d  = found[N];
          rej_d    = 1'b0;
          evc_d    = '0;
          used_d   = total_q;
          state_d  = locd_pkg::ST_IDLE;
        end else if (too_big) begin
          done_d  = 1'b1;
          hit_d   = 1'b0;
          found_d = '0;
          rej_d   = 1'b1;
          evc_d   = '0;
          used_d  = total_q;
          state_d = locd_pkg::ST_IDLE;
        end else begin
          cnt_d   = '0;
          state_d = locd_pkg::ST_EVICT;
        end
      end
      locd_pkg::ST_EVICT: begin
        if (need_evict) begin
          // drop the oldest entry, one per cycle
          total_d = after_evict;
          if (cnt_q != '1) begin
            cnt_d = cnt_q + 1'b1;
          end
        end else begin
          total_d = base_used + locd_pkg::USED_W'(charge);
          done_d  = 1'b1;
          hit_d   = 1'b0;
          found_d = '0;
          rej_d   = 1'b0;
          evc_d   = cnt_q;
          used_d  = base_used + locd_pkg::USED_W'(charge);
          state_d = locd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = locd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= locd_pkg::ST_IDLE;
      total_q <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q   <= hit_d;
    found_q <= found_d;
    rej_q   <= rej_d;
    evc_q   <= evc_d;
    used_q  <= used_d;
  end

  assign done_o          = done_q;
  assign hit_o           = hit_q;
  assign found_size_o    = found_q;
  assign rejected_o      = rej_q;
  assign evicted_count_o = evc_q;
  assign used_bytes_o    = used_q;

endmodule

>>> rtl/locd_checker.sv
module locd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          done_o,
  input logic                          hit_o,
  input logic [locd_pkg::SIZE_W-1:0]   found_size_o,
  input logic                          rejected_o,
  input logic [locd_pkg::CNT_W-1:0]    evicted_count_o
);

  // an accepted item always occupies the block for the following cycle
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after start");

  // the block only goes idle by delivering a result
  a_done_on_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

  a_hit_not_rej: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(hit_o && rejected_o))
    else $error("result both hit and rejected");

  a_miss_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !hit_o |-> found_size_o == '0)
    else $error("found size on a miss");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (hit_o || rejected_o) |-> evicted_count_o == '0)
    else $error("eviction reported on lookup or reject");

endmodule

bind lru_object_cache_directory_core locd_checker u_locd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .hit_o           (hit_o),
  .found_size_o    (found_size_o),
  .rejected_o      (rejected_o),
  .evicted_count_o (evicted_count_o)
);

>>> verif/lru_object_cache_directory_core_tb.sv
`timescale 1ns / 100ps

module lru_object_cache_directory_core_tb;
  import locd_pkg::*;

  localparam logic        MODE_LOOKUP = 1'b0;
  localparam logic        MODE_INSERT = 1'b1;
  localparam logic [39:0] KEY_MAX     = 40'd999999999988;
  localparam int unsigned SIZE_MAX    = 1048576;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned NUM_PHASES  = 6;

  // one directory result, field order matches the result ports
  typedef struct packed {
    logic              hit;
    logic [SIZE_W-1:0] found_size;
    logic              rejected;
    logic [CNT_W-1:0]  evicted_count;
    logic [USED_W-1:0] used_bytes;
  } dir_result_t;

  // Mirror of the directory: slot 0 oldest, live slots form a prefix.
  class lru_dir_scoreboard;
    logic [KEY_W-1:0]  slot_key[ENTRIES];
    logic [SIZE_W-1:0] slot_size[ENTRIES];
    int unsigned       live;
    int unsigned       used;
    int unsigned       capacity;
    int unsigned       max_obj;
    int unsigned       header;
    dir_result_t       expected_results[$];
    int unsigned       errors;
    int unsigned       n_lookups, n_hits, n_inserts, n_rejects, n_evicted;

    function new();
      live     = 0;
      used     = 0;
      capacity = CAPACITY_RST;
      max_obj  = MAX_OBJ_RST;
      header   = HEADER_RST;
      errors   = 0;
      n_lookups = 0; n_hits = 0; n_inserts = 0; n_rejects = 0; n_evicted = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_CAPACITY: capacity = data;
        REG_MAX_OBJ:  max_obj  = data[SIZE_W-1:0];
        REG_HEADER:   header   = data[HDR_W-1:0];
        default: ;
      endcase
    endfunction

    // drop the head entry, shifting the row toward slot 0
    function void pop_oldest();
      for (int unsigned j = 0; j + 1 < live; j++) begin
        slot_key[j]  = slot_key[j+1];
        slot_size[j] = slot_size[j+1];
      end
      live--;
    endfunction

    // accepted request: advance the mirror and queue the result it must give
    function void note_request(logic mode, logic [KEY_W-1:0] key, logic [SIZE_W-1:0] size);
      dir_result_t       r;
      int unsigned       match;
      int unsigned       charge;
      int unsigned       c;
      logic [SIZE_W-1:0] s;
      r = '0;
      if (mode == MODE_LOOKUP) begin
        n_lookups++;
        match = live;
        for (int unsigned i = 0; i < live; i++)
          if (slot_key[i] == key && match == live) match = i;
        if (match < live) begin
          // hit moves the oldest matching entry to the newest slot
          s = slot_size[match];
          r.hit = 1'b1;
          r.found_size = s;
          for (int unsigned j = match; j + 1 < live; j++) begin
            slot_key[j]  = slot_key[j+1];
            slot_size[j] = slot_size[j+1];
          end
          slot_key[live-1]  = key;
          slot_size[live-1] = s;
          n_hits++;
        end
      end else begin
        n_inserts++;
        charge = size + header;
        if (size > max_obj || charge > capacity) begin
          r.rejected = 1'b1;
          n_rejects++;
        end else begin
          // evict with the current header, clamp at zero
          while (live > 0 && (used + charge > capacity || live >= ENTRIES)) begin
            c = slot_size[0] + header;
            used = (c >= used) ? 0 : used - c;
            pop_oldest();
            if (r.evicted_count < 31) r.evicted_count++;
            n_evicted++;
          end
          if (live == 0) used = 0;
          slot_key[live]  = key;
          slot_size[live] = size;
          live++;
          used = (used + charge) & 32'hFF_FFFF;
        end
      end
      r.used_bytes = used[USED_W-1:0];
      expected_results.push_back(r);
    endfunction

    function void check_result(dir_result_t got);
      dir_result_t want;
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.hit !== want.hit) begin
        $error("hit: expected %0d, got %0d", want.hit, got.hit);
        errors++;
      end
      if (got.found_size !== want.found_size) begin
        $error("found_size: expected %0d, got %0d", want.found_size, got.found_size);
        errors++;
      end
      if (got.rejected !== want.rejected) begin
        $error("rejected: expected %0d, got %0d", want.rejected, got.rejected);
        errors++;
      end
      if (got.evicted_count !== want.evicted_count) begin
        $error("evicted_count: expected %0d, got %0d", want.evicted_count,
               got.evicted_count);
        errors++;
      end
      if (got.used_bytes !== want.used_bytes) begin
        $error("used_bytes: expected %0d, got %0d", want.used_bytes, got.used_bytes);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic              mode_i;
  logic [KEY_W-1:0]  key_i;
  logic [SIZE_W-1:0] obj_size_i;
  logic              done_o;
  logic              hit_o;
  logic [SIZE_W-1:0] found_size_o;
  logic              rejected_o;
  logic [CNT_W-1:0]  evicted_count_o;
  logic [USED_W-1:0] used_bytes_o;
  logic              cfg_we_i;
  logic [CIDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]  cfg_data_i;

  lru_dir_scoreboard sb;
  int unsigned       cycles = 0;
  logic [KEY_W-1:0]  key_pool[20];

  lru_object_cache_directory_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .mode_i          (mode_i),
    .key_i           (key_i),
    .obj_size_i      (obj_size_i),
    .done_o          (done_o),
    .hit_o           (hit_o),
    .found_size_o    (found_size_o),
    .rejected_o      (rejected_o),
    .evicted_count_o (evicted_count_o),
    .used_bytes_o    (used_bytes_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Results cannot be stalled: every done_o cycle is checked at the edge
  // that closes it.
  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_result({hit_o, found_size_o, rejected_o, evicted_count_o, used_bytes_o});
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("lru_object_cache_directory_core_tb: FAIL");
      $finish;
    end
  end

  function automatic logic [KEY_W-1:0] rand_key();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return KEY_W'(v % (64'(KEY_MAX) + 64'd1));
  endfunction

  // Drop start for the idle gap that 'gap' gives, then present one item and hold start until it is taken.
  task automatic send_request(logic mode, logic [KEY_W-1:0] key,
                              logic [SIZE_W-1:0] size, int unsigned gap);
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start      <= 1'b1;
    mode_i     <= mode;
    key_i      <= key;
    obj_size_i <= size;
    do @(posedge clk_i); while (busy);
    sb.note_request(mode, key, size);
  endtask

  // Sender holds off until every outstanding result has come back.
  task automatic wait_for_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
  endtask

  // only called with the directory idle
  task automatic write_reg(reg_idx_e idx, logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  // Directed opening: empty lookup, size extremes, both rejection kinds,
  // duplicate keys, full-row eviction, shrunken capacity, changed header.
  task automatic directed_items();
    send_request(MODE_LOOKUP, '0, '0, 0);             // miss on empty
    send_request(MODE_INSERT, '0, '0, 0);             // smallest object
    send_request(MODE_INSERT, KEY_MAX, 21'd102400, 0); // exactly max_object
    send_request(MODE_INSERT, 40'd7, 21'd102401, 1);   // oversized
    send_request(MODE_INSERT, 40'd8, SIZE_MAX[SIZE_W-1:0], 0);
    send_request(MODE_LOOKUP, '0, '1, 2);             // hit, moves to newest
    send_request(MODE_INSERT, '0, 21'd5, 0);          // duplicate key
    send_request(MODE_LOOKUP, '0, '0, 0);             // oldest duplicate wins
    send_request(MODE_LOOKUP, KEY_MAX, '0, 0);
    send_request(MODE_LOOKUP, 40'd12345, '0, 3);       // miss
    // overflow the slot count with small objects
    for (int i = 0; i < 14; i++)
      send_request(MODE_INSERT, 40'd100 + i, 21'd2000, (i % 3 == 0) ? 1 : 0);
    wait_for_results();
    // capacity now far below use, header raised: evictions overshoot and clamp
    write_reg(REG_CAPACITY, 24'd5000);
    write_reg(REG_HEADER, 24'd255);
    send_request(MODE_INSERT, 40'd1, 21'd100, 0);
    send_request(MODE_INSERT, 40'd2, 21'd4800, 0);    // charge above capacity
    wait_for_results();
  endtask

  initial begin
    int unsigned cap_tbl[NUM_PHASES]  = '{1049000, 3000, 16777215, 1, 50000, 400};
    int unsigned max_tbl[NUM_PHASES]  = '{102400, 600, 1048576, 1, 8000, 1048576};
    int unsigned hdr_tbl[NUM_PHASES]  = '{32, 0, 255, 0, 200, 17};
    int unsigned len_tbl[NUM_PHASES]  = '{170, 170, 160, 110, 170, 170};
    int unsigned lim;
    int unsigned sel;
    int unsigned gap;
    logic        mode;
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] size;

    sb         = new();
    rst_ni     = 1'b0;
    start      = 1'b0;
    mode_i     = MODE_LOOKUP;
    key_i      = '0;
    obj_size_i = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = REG_CAPACITY;
    cfg_data_i = '0;

    // small key pool so lookups hit and inserts duplicate
    key_pool[0] = '0;
    key_pool[1] = KEY_MAX;
    for (int i = 2; i < 20; i++) key_pool[i] = rand_key();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    directed_items();

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_for_results();
      write_reg(REG_CAPACITY, CFG_W'(cap_tbl[p]));
      write_reg(REG_MAX_OBJ, CFG_W'(max_tbl[p]));
      write_reg(REG_HEADER, CFG_W'(hdr_tbl[p]));
      // keep sizes modest relative to capacity so evictions stay frequent
      lim = (cap_tbl[p] / 3 + 1 < max_tbl[p]) ? cap_tbl[p] / 3 + 1 : max_tbl[p];
      for (int n = 0; n < len_tbl[p]; n++) begin
        mode = ($urandom_range(0, 99) < 55) ? MODE_INSERT : MODE_LOOKUP;
        key  = ($urandom_range(0, 4) == 0) ? rand_key() : key_pool[$urandom_range(0, 19)];
        sel  = $urandom_range(0, 19);
        if (sel < 2)
          size = SIZE_W'($urandom_range(max_tbl[p], SIZE_MAX));   // usually oversized
        else if (sel == 2)
          size = '0;
        else if (sel == 3)
          size = SIZE_W'(max_tbl[p]);
        else
          size = SIZE_W'($urandom_range(0, lim));
        if (mode == MODE_LOOKUP && $urandom_range(0, 3) == 0)
          size = SIZE_W'($urandom_range(0, SIZE_MAX));            // don't-care on lookups
        // last phase runs back to back
        gap = (p != NUM_PHASES - 1 && $urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0;
        if (p != NUM_PHASES - 1 && $urandom_range(0, 99) == 0) wait_for_results();
        send_request(mode, key, size, gap);
      end
    end

    wait_for_results();
    repeat (30) @(posedge clk_i);
    if (sb.expected_results.size() != 0) begin
      $error("%0d results never arrived", sb.expected_results.size());
      sb.errors++;
    end

    $display("run covered %0d lookups (%0d hits) and %0d inserts (%0d refused),",
             sb.n_lookups, sb.n_hits, sb.n_inserts, sb.n_rejects);
    $display("%0d evictions across %0d register settings, %0d mismatches",
             sb.n_evicted, NUM_PHASES + 2, sb.errors);
    if (sb.errors == 0)
      $display("lru_object_cache_directory_core_tb: PASS");
    else
      $display("lru_object_cache_directory_core_tb: FAIL");
    $finish;
  end

endmodule
